// File: rtl/assert_macros.svh
// assertion macros used by the encoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ooke_pkg.sv
// types and constants of the ook pulse train encoder
`timescale 1ns / 1ps

package ooke_pkg;

  typedef enum logic [1:0] {
    SEG_SYNC  = 2'd0,
    SEG_DATA  = 2'd1,
    SEG_PAUSE = 2'd2
  } seg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_HIGH_TIME  = 3'd0,
    REG_SYNC_LOW   = 3'd1,
    REG_ONE_LOW    = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_PAUSE_LOW  = 3'd4,
    REG_REPEAT_CNT = 3'd5
  } reg_idx_t;

  localparam logic [15:0] HIGH_TIME_RST  = 16'd250;
  localparam logic [15:0] SYNC_LOW_RST   = 16'd2500;
  localparam logic [15:0] ONE_LOW_RST    = 16'd1250;
  localparam logic [15:0] ZERO_LOW_RST   = 16'd250;
  localparam logic [15:0] PAUSE_LOW_RST  = 16'd10000;
  localparam logic [7:0]  REPEAT_CNT_RST = 8'd5;

  localparam int ADDR_W = 5;

endpackage

// File: rtl/ook_pulse_train_encoder_core.sv
// ook pulse train encoder: start/tick beats in, one line level beat out per item
// the result beat of an accepted input beat is registered and appears in the next cycle
// throughput: one item per cycle while in_stall is low; the state update and output register close in the same cycle
// in_stall rises only while a result beat waits and out_stall holds it
// reset (rst_n low, synchronous): idle, no result pending, registers at their defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ook_pulse_train_encoder_core #(
  parameter int WORD_BITS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [31:0]                   in_data_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_line_level,
  output logic                          out_busy_res,
  output logic                          out_start_rejected,
  output logic                          out_done_res,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ooke_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int BP_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [BP_W-1:0] BP_TOP = BP_W'(WORD_BITS - 1);
  localparam logic [23:0] TIME_MAX = 24'((25'd1 << TIME_BITS) - 25'd1);

  // configuration registers
  logic [15:0] high_time_r, sync_low_r, one_low_r, zero_low_r, pause_low_r;
  logic [7:0]  repeat_cnt_r;

  // encoder state
  logic [WORD_BITS-1:0] shift_word_r, shift_word_nxt;
  logic [BP_W-1:0]      bit_pos_r, bit_pos_nxt;
  ooke_pkg::seg_t       seg_r, seg_nxt;
  logic                 second_half_r, second_half_nxt;
  logic                 in_low_r, in_low_nxt;
  logic [TIME_BITS-1:0] time_left_r, time_left_nxt;
  logic [7:0]           repeats_left_r, repeats_left_nxt;
  logic                 active_r, active_nxt;

  // result register
  logic out_valid_r;
  logic level_r, busy_r, rejected_r, done_r;
  logic level_nxt, busy_nxt, rejected_nxt, done_nxt;

  logic                 in_accept;
  logic                 cfg_wr;
  logic [63:0]          data_ext;
  logic [TIME_BITS-1:0] time_dec;
  logic [TIME_BITS-1:0] low_time;
  logic                 cur_bit;

  function automatic logic [TIME_BITS-1:0] clamp_time(input logic [15:0] d);
    logic [23:0] ext;
    ext = 24'(d);
    if (d == 16'd0) begin
      return TIME_BITS'(1);
    end else if (ext > TIME_MAX) begin
      return TIME_MAX[TIME_BITS-1:0];
    end else begin
      return ext[TIME_BITS-1:0];
    end
  endfunction

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_time_r  <= ooke_pkg::HIGH_TIME_RST;
      sync_low_r   <= ooke_pkg::SYNC_LOW_RST;
      one_low_r    <= ooke_pkg::ONE_LOW_RST;
      zero_low_r   <= ooke_pkg::ZERO_LOW_RST;
      pause_low_r  <= ooke_pkg::PAUSE_LOW_RST;
      repeat_cnt_r <= ooke_pkg::REPEAT_CNT_RST;
    end else if (cfg_wr) begin
      case (ooke_pkg::reg_idx_t'(paddr[ooke_pkg::ADDR_W-1:2]))
        ooke_pkg::REG_HIGH_TIME:  high_time_r  <= pwdata[15:0];
        ooke_pkg::REG_SYNC_LOW:   sync_low_r   <= pwdata[15:0];
        ooke_pkg::REG_ONE_LOW:    one_low_r    <= pwdata[15:0];
        ooke_pkg::REG_ZERO_LOW:   zero_low_r   <= pwdata[15:0];
        ooke_pkg::REG_PAUSE_LOW:  pause_low_r  <= pwdata[15:0];
        ooke_pkg::REG_REPEAT_CNT: repeat_cnt_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ooke_pkg::reg_idx_t'(paddr[ooke_pkg::ADDR_W-1:2]))
      ooke_pkg::REG_HIGH_TIME:  prdata = 32'(high_time_r);
      ooke_pkg::REG_SYNC_LOW:   prdata = 32'(sync_low_r);
      ooke_pkg::REG_ONE_LOW:    prdata = 32'(one_low_r);
      ooke_pkg::REG_ZERO_LOW:   prdata = 32'(zero_low_r);
      ooke_pkg::REG_PAUSE_LOW:  prdata = 32'(pause_low_r);
      ooke_pkg::REG_REPEAT_CNT: prdata = 32'(repeat_cnt_r);
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------- pulse sequencer ----------------
  assign data_ext = 64'(in_data_word);
  assign cur_bit  = shift_word_r[bit_pos_r];
  assign time_dec = (time_left_r != '0) ? time_left_r - TIME_BITS'(1) : time_left_r;

  // low time of the pulse now running, from the state before this beat
  always_comb begin
    case (seg_r)
      ooke_pkg::SEG_SYNC: low_time = clamp_time(sync_low_r);
      ooke_pkg::SEG_DATA:
        low_time = clamp_time((cur_bit ^ second_half_r) ? one_low_r : zero_low_r);
      default:            low_time = clamp_time(pause_low_r);
    endcase
  end

  always_comb begin
    shift_word_nxt   = shift_word_r;
    bit_pos_nxt      = bit_pos_r;
    seg_nxt          = seg_r;
    second_half_nxt  = second_half_r;
    in_low_nxt       = in_low_r;
    time_left_nxt    = time_left_r;
    repeats_left_nxt = repeats_left_r;
    active_nxt       = active_r;
    level_nxt        = 1'b0;
    busy_nxt         = 1'b0;
    rejected_nxt     = 1'b0;
    done_nxt         = 1'b0;

    if (in_opcode == ooke_pkg::OP_START) begin
      busy_nxt = 1'b1;
      if (active_r) begin
        rejected_nxt = 1'b1;
      end else begin
        shift_word_nxt   = data_ext[WORD_BITS-1:0];
        bit_pos_nxt      = BP_TOP;
        seg_nxt          = ooke_pkg::SEG_SYNC;
        second_half_nxt  = 1'b0;
        in_low_nxt       = 1'b0;
        time_left_nxt    = clamp_time(high_time_r);
        repeats_left_nxt = (repeat_cnt_r == 8'd0) ? 8'd1 : repeat_cnt_r;
        active_nxt       = 1'b1;
      end
    end else if (active_r) begin
      busy_nxt      = 1'b1;
      level_nxt     = ~in_low_r;
      time_left_nxt = time_dec;
      if (time_dec == '0) begin
        if (!in_low_r) begin
          in_low_nxt    = 1'b1;
          time_left_nxt = low_time;
        end else begin
          in_low_nxt    = 1'b0;
          time_left_nxt = clamp_time(high_time_r);
          case (seg_r)
            ooke_pkg::SEG_SYNC: begin
              seg_nxt         = ooke_pkg::SEG_DATA;
              bit_pos_nxt     = BP_TOP;
              second_half_nxt = 1'b0;
            end
            ooke_pkg::SEG_DATA: begin
              second_half_nxt = ~second_half_r;
              if (second_half_r) begin
                if (bit_pos_r == '0) begin
                  seg_nxt = ooke_pkg::SEG_PAUSE;
                end else begin
                  bit_pos_nxt = bit_pos_r - BP_W'(1);
                end
              end
            end
            default: begin
              // end of a frame: repeat or finish
              repeats_left_nxt = repeats_left_r - 8'd1;
              seg_nxt          = ooke_pkg::SEG_SYNC;
              if (repeats_left_r == 8'd1) begin
                active_nxt    = 1'b0;
                done_nxt      = 1'b1;
                time_left_nxt = '0;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_word_r   <= '0;
      bit_pos_r      <= '0;
      seg_r          <= ooke_pkg::SEG_SYNC;
      second_half_r  <= 1'b0;
      in_low_r       <= 1'b0;
      time_left_r    <= '0;
      repeats_left_r <= 8'd0;
      active_r       <= 1'b0;
    end else if (in_accept) begin
      shift_word_r   <= shift_word_nxt;
      bit_pos_r      <= bit_pos_nxt;
      seg_r          <= seg_nxt;
      second_half_r  <= second_half_nxt;
      in_low_r       <= in_low_nxt;
      time_left_r    <= time_left_nxt;
      repeats_left_r <= repeats_left_nxt;
      active_r       <= active_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      level_r    <= level_nxt;
      busy_r     <= busy_nxt;
      rejected_r <= rejected_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line_level     = level_r;
  assign out_busy_res       = busy_r;
  assign out_start_rejected = rejected_r;
  assign out_done_res       = done_r;

  // ---------------- assertions ----------------
  `CHK_NOW(a_done_is_low_tick, clk, rst_n, out_valid_r && done_r, busy_r && !level_r && !rejected_r, "done beat must be a busy low tick")
  `CHK_NEXT(a_done_goes_idle, clk, rst_n, in_accept && done_nxt, !active_r, "encoder still active after done")
  `CHK_NOW(a_idle_clean, clk, rst_n, !active_r, time_left_r == '0 && !in_low_r, "idle state carries a pending pulse")
  `CHK_NEXT(a_start_loads, clk, rst_n, in_accept && in_opcode == ooke_pkg::OP_START && !active_r, active_r && repeats_left_r != 8'd0 && time_left_r != '0, "start did not load a frame")

endmodule

// File: test/ook_pulse_train_encoder_core_test.sv
// self-checking testbench for the ook pulse train encoder core
`timescale 1ns / 1ps

module ook_pulse_train_encoder_core_test;

  localparam int TOP_BIT = 31;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // receiver stall patterns
  localparam int STALL_NONE = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY = 3;

  typedef struct packed {
    ooke_pkg::opcode_t op;
    logic [31:0]       word;
  } enc_cmd_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic rejected;
    logic done;
  } line_beat_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_opcode;
  logic [31:0]                 in_data_word;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_line_level;
  logic                        out_busy_res;
  logic                        out_start_rejected;
  logic                        out_done_res;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ooke_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  ook_pulse_train_encoder_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_data_word       (in_data_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_line_level     (out_line_level),
    .out_busy_res       (out_busy_res),
    .out_start_rejected (out_start_rejected),
    .out_done_res       (out_done_res),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // encoder settings as the block should hold them
  logic [15:0] cfg_high, cfg_sync, cfg_one, cfg_zero, cfg_pause;
  logic [7:0]  cfg_repeat;

  // transmitter state as the block should hold it
  logic [31:0]    tx_word;
  logic [4:0]     tx_bit;
  ooke_pkg::seg_t tx_seg;
  logic           tx_second;
  logic           tx_low;
  logic [15:0]    tx_left;
  logic [7:0]     tx_frames;
  logic           enc_active;

  enc_cmd_t   cmd_q[$];
  line_beat_t line_beats_due[$];

  int err_count;
  int cycles;
  logic in_took;
  int burst_left, gap_left;
  bit send_smooth;
  int stall_mode;
  int pat_cnt;
  int hold_asks, hold_seen, hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] at_least_one(logic [15:0] d);
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  function automatic logic [15:0] low_part_len();
    case (tx_seg)
      ooke_pkg::SEG_SYNC: return at_least_one(cfg_sync);
      ooke_pkg::SEG_DATA:
        return at_least_one((tx_word[tx_bit] ^ tx_second) ? cfg_one : cfg_zero);
      default: return at_least_one(cfg_pause);
    endcase
  endfunction

  // advances the transmitter by one beat and returns the line beat it yields
  function automatic line_beat_t encode_step(enc_cmd_t cmd);
    line_beat_t r;
    r = '0;
    if (cmd.op == ooke_pkg::OP_START) begin
      if (enc_active) begin
        r.rejected = 1'b1;
      end else begin
        tx_word = cmd.word;
        tx_bit = 5'(TOP_BIT);
        tx_seg = ooke_pkg::SEG_SYNC;
        tx_second = 1'b0;
        tx_low = 1'b0;
        tx_left = at_least_one(cfg_high);
        tx_frames = (cfg_repeat == 8'd0) ? 8'd1 : cfg_repeat;
        enc_active = 1'b1;
      end
      r.busy = 1'b1;
    end else if (enc_active) begin
      r.busy = 1'b1;
      r.level = !tx_low;
      if (tx_left != 16'd0) tx_left = tx_left - 16'd1;
      if (tx_left == 16'd0) begin
        if (!tx_low) begin
          tx_low = 1'b1;
          tx_left = low_part_len();
        end else begin
          tx_low = 1'b0;
          tx_left = at_least_one(cfg_high);
          case (tx_seg)
            ooke_pkg::SEG_SYNC: begin
              tx_seg = ooke_pkg::SEG_DATA;
              tx_bit = 5'(TOP_BIT);
              tx_second = 1'b0;
            end
            ooke_pkg::SEG_DATA: begin
              if (!tx_second) begin
                tx_second = 1'b1;
              end else begin
                tx_second = 1'b0;
                if (tx_bit == 5'd0) tx_seg = ooke_pkg::SEG_PAUSE;
                else tx_bit = tx_bit - 5'd1;
              end
            end
            default: begin
              tx_frames = tx_frames - 8'd1;
              tx_seg = ooke_pkg::SEG_SYNC;
              if (tx_frames == 8'd0) begin
                enc_active = 1'b0;
                r.done = 1'b1;
                tx_left = 16'd0;
              end
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  // input side: accepted beats feed the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        line_beats_due.push_back(
          encode_step('{ooke_pkg::opcode_t'(in_opcode), in_data_word}));
    end
  end

  // sender: bursts of beats with random gaps, or with no gaps in smooth mode
  always @(negedge clk) begin
    enc_cmd_t cmd;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
        in_data_word <= $urandom;
      end else if (cmd_q.size() != 0) begin
        cmd = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= cmd.op;
        in_data_word <= cmd.word;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = send_smooth ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    logic stall_n;
    stall_n = 1'b0;
    pat_cnt++;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_n = 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: stall_n = ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: stall_n = ((pat_cnt % 7) < 3);
        STALL_HEAVY: stall_n = ($urandom_range(0, 99) < 70);
        default: stall_n = 1'b0;
      endcase
    end
    out_stall <= stall_n;
  end

  // result side: compare each beat with the oldest prediction
  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_beats_due.size() == 0) begin
        $error("result beat with no prediction waiting");
        err_count++;
      end else begin
        want = line_beats_due.pop_front();
        if (out_line_level !== want.level) begin
          $error("line_level: expected %0d, got %0d", want.level, out_line_level);
          err_count++;
        end
        if (out_busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, out_busy_res);
          err_count++;
        end
        if (out_start_rejected !== want.rejected) begin
          $error("start_rejected: expected %0d, got %0d", want.rejected, out_start_rejected);
          err_count++;
        end
        if (out_done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_done_res);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] rd, wdata, mask;
    wdata = {16'($urandom), val};
    apb_access(1'b1, idx, wdata, rd);
    mask = 32'h0000_ffff;
    case (idx)
      ooke_pkg::REG_HIGH_TIME: cfg_high = val;
      ooke_pkg::REG_SYNC_LOW: cfg_sync = val;
      ooke_pkg::REG_ONE_LOW: cfg_one = val;
      ooke_pkg::REG_ZERO_LOW: cfg_zero = val;
      ooke_pkg::REG_PAUSE_LOW: cfg_pause = val;
      ooke_pkg::REG_REPEAT_CNT: begin
        cfg_repeat = val[7:0];
        mask = 32'h0000_00ff;
      end
      default: mask = 32'h0;
    endcase
    if (mask != 32'h0) begin
      apb_access(1'b0, idx, 32'h0, rd);
      if ((rd & mask) !== (wdata & mask)) begin
        $error("register %0d readback: expected %0h, got %0h", idx, wdata & mask, rd & mask);
        err_count++;
      end
    end
  endtask

  task automatic set_timing(input logic [15:0] high, input logic [15:0] sync,
                            input logic [15:0] one, input logic [15:0] zero,
                            input logic [15:0] pause, input logic [7:0] frames);
    set_reg(ooke_pkg::REG_HIGH_TIME, high);
    set_reg(ooke_pkg::REG_SYNC_LOW, sync);
    set_reg(ooke_pkg::REG_ONE_LOW, one);
    set_reg(ooke_pkg::REG_ZERO_LOW, zero);
    set_reg(ooke_pkg::REG_PAUSE_LOW, pause);
    set_reg(ooke_pkg::REG_REPEAT_CNT, {8'h0, frames});
  endtask

  task automatic queue_cmd(input ooke_pkg::opcode_t op, input logic [31:0] word);
    cmd_q.push_back('{op, word});
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_cmd(ooke_pkg::OP_TICK, $urandom);
  endtask

  // mostly ticks, with the odd start that lands idle or gets rejected
  task automatic queue_traffic(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 4) queue_cmd(ooke_pkg::OP_START, $urandom);
      else queue_cmd(ooke_pkg::OP_TICK, $urandom);
    end
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_valid || line_beats_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = ooke_pkg::OP_TICK;
    in_data_word = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    cycles = 0;
    burst_left = 0;
    gap_left = 0;
    send_smooth = 1'b0;
    stall_mode = STALL_NONE;
    pat_cnt = 0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    cfg_high = ooke_pkg::HIGH_TIME_RST;
    cfg_sync = ooke_pkg::SYNC_LOW_RST;
    cfg_one = ooke_pkg::ONE_LOW_RST;
    cfg_zero = ooke_pkg::ZERO_LOW_RST;
    cfg_pause = ooke_pkg::PAUSE_LOW_RST;
    cfg_repeat = ooke_pkg::REPEAT_CNT_RST;
    tx_word = '0;
    tx_bit = '0;
    tx_seg = ooke_pkg::SEG_SYNC;
    tx_second = 1'b0;
    tx_low = 1'b0;
    tx_left = '0;
    tx_frames = '0;
    enc_active = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks, accepted and rejected starts, word extremes
    set_timing(16'd1, 16'd2, 16'd3, 16'd1, 16'd2, 8'd1);
    queue_cmd(ooke_pkg::OP_TICK, 32'h0000_0000);
    queue_cmd(ooke_pkg::OP_TICK, 32'hffff_ffff);
    queue_cmd(ooke_pkg::OP_START, 32'h8000_0001);
    queue_cmd(ooke_pkg::OP_START, 32'hffff_ffff);
    queue_ticks(12);
    queue_cmd(ooke_pkg::OP_START, 32'h0000_0000);
    queue_ticks(6);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 4;
      send_smooth = (ph == 3);
      if (ph == 0) begin
        // zero durations act as one tick, zero repeat as one frame
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
      end else begin
        set_timing(16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 8'($urandom_range(0, 2)));
      end
      if (ph == 2) begin
        // writes past the last register must be ignored
        set_reg(REG_SPARE_LO, 16'($urandom));
        set_reg(REG_SPARE_HI, 16'($urandom));
      end
      queue_traffic(175);
      if (ph == 1) hold_asks++;
      drain();
    end

    // run the current transmission out so the next start lands idle
    stall_mode = STALL_RANDOM;
    send_smooth = 1'b0;
    while (enc_active) begin
      queue_ticks(64);
      drain();
    end

    // largest settings: load them and watch the first pulse for a while
    set_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    queue_cmd(ooke_pkg::OP_START, $urandom);
    queue_ticks(100);
    queue_cmd(ooke_pkg::OP_START, $urandom);
    queue_ticks(100);
    drain();

    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
